@@ rtl/bfa_pkg.sv @@
// Shared types, codes and defaults for the best-fit block allocator.
package bfa_pkg;

   localparam int NUM_BLOCKS_DEFAULT = 16;
   localparam int SIZE_BITS_DEFAULT  = 16;

   localparam int INDEX_BITS  = 4;
   localparam int AMOUNT_BITS = 16;
   localparam int CSR_BITS    = 5;
   localparam int TDATA_BITS  = 24;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_ALLOC = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic start;
      logic issue;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic is_alloc;
      logic limit_zero;
      logic scan_last;
      logic rsp_free;
   } status_type;

endpackage

@@ rtl/bfa_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module bfa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/bfa_ctrl.sv @@
// Controller state machine that sequences loads, the best-fit scan and the result.
module bfa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  bfa_pkg::status_type   status,
   output bfa_pkg::cmd_type      cmd
);

   bfa_pkg::state_type state_ff;
   bfa_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bfa_pkg::ST_IDLE: begin
            if (req_tvalid && status.is_alloc) begin
               state_in = status.limit_zero ? bfa_pkg::ST_FINISH : bfa_pkg::ST_SCAN;
            end
         end
         bfa_pkg::ST_SCAN: begin
            if (status.scan_last) begin
               state_in = bfa_pkg::ST_DRAIN;
            end
         end
         bfa_pkg::ST_DRAIN: begin
            state_in = bfa_pkg::ST_FINISH;
         end
         bfa_pkg::ST_FINISH: begin
            if (status.rsp_free) begin
               state_in = bfa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bfa_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         bfa_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid && !status.is_alloc;
            cmd.start  = req_tvalid && status.is_alloc;
         end
         bfa_pkg::ST_SCAN: begin
            cmd.issue = 1'b1;
         end
         bfa_pkg::ST_DRAIN: begin
            cmd = '0;
         end
         bfa_pkg::ST_FINISH: begin
            cmd.finish = status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ rtl/bfa_datapath.sv @@
// Datapath: free-size memory, scan counter, best-fit compare and result register.
module bfa_datapath #(
   parameter int NUM_BLOCKS = bfa_pkg::NUM_BLOCKS_DEFAULT,
   parameter int SIZE_BITS  = bfa_pkg::SIZE_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [bfa_pkg::TDATA_BITS-1:0]  req_tdata,
   input  logic                            req_tuser,
   input  logic                            csr_valid,
   input  logic [bfa_pkg::CSR_BITS-1:0]    csr_data,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bfa_pkg::TDATA_BITS-1:0]  rsp_tdata,
   output logic                            rsp_tuser,
   input  bfa_pkg::cmd_type                cmd,
   output bfa_pkg::status_type             status
);

   localparam int IDX_BITS = $clog2(NUM_BLOCKS);
   localparam int CNT_BITS = $clog2(NUM_BLOCKS + 1);

   logic [bfa_pkg::INDEX_BITS-1:0]  req_index;
   logic [bfa_pkg::AMOUNT_BITS-1:0] req_amount;
   logic [31:0]                     amount_wide;
   logic [SIZE_BITS-1:0]            amount_sized;
   logic                            load_in_range;

   logic [bfa_pkg::CSR_BITS-1:0]    blocks_in_use_ff;
   logic [8:0]                      blocks_wide;
   logic [8:0]                      limit_wide;
   logic [CNT_BITS-1:0]             limit;

   logic [SIZE_BITS-1:0]            amount_ff;
   logic [IDX_BITS-1:0]             cnt_ff;
   logic                            cmp_valid_ff;
   logic [IDX_BITS-1:0]             cmp_idx_ff;
   logic                            best_found_ff;
   logic [IDX_BITS-1:0]             best_idx_ff;
   logic [SIZE_BITS-1:0]            best_size_ff;
   logic                            fits;

   logic [SIZE_BITS-1:0]            rd_data;
   logic                            wr_en;
   logic [IDX_BITS-1:0]             wr_addr;
   logic [SIZE_BITS-1:0]            wr_data;
   logic [SIZE_BITS-1:0]            new_size;
   logic [31:0]                     new_size_wide;
   logic [31:0]                     best_idx_wide;

   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   logic                            rsp_granted_ff;
   logic [bfa_pkg::INDEX_BITS-1:0]  rsp_block_ff;
   logic [bfa_pkg::AMOUNT_BITS-1:0] rsp_left_ff;

   assign req_index     = req_tdata[3:0];
   assign req_amount    = req_tdata[19:4];
   assign amount_wide   = 32'(req_amount);
   assign amount_sized  = amount_wide[SIZE_BITS-1:0];
   assign load_in_range = 9'(req_index) < 9'(NUM_BLOCKS);

   // Entries beyond the table take no part in the search.
   assign blocks_wide = 9'(blocks_in_use_ff);
   assign limit_wide  = (blocks_wide > 9'(NUM_BLOCKS)) ? 9'(NUM_BLOCKS) : blocks_wide;
   assign limit       = CNT_BITS'(limit_wide);

   always_ff @(posedge clock) begin
      if (reset) begin
         blocks_in_use_ff <= '0;
      end else if (csr_valid) begin
         blocks_in_use_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         amount_ff <= amount_sized;
      end
      if (cmd.start) begin
         cnt_ff <= '0;
      end else if (cmd.issue) begin
         cnt_ff <= cnt_ff + IDX_BITS'(1);
      end
      cmp_idx_ff <= cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_valid_ff <= 1'b0;
      end else begin
         cmp_valid_ff <= cmd.issue;
      end
   end

   // The strict less-than keeps the lowest index among equal sizes.
   assign fits = cmp_valid_ff && (rd_data >= amount_ff) &&
                 (!best_found_ff || (rd_data < best_size_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         best_found_ff <= 1'b0;
      end else if (cmd.start) begin
         best_found_ff <= 1'b0;
      end else if (fits) begin
         best_found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (fits) begin
         best_idx_ff  <= cmp_idx_ff;
         best_size_ff <= rd_data;
      end
   end

   assign new_size      = best_size_ff - amount_ff;
   assign new_size_wide = 32'(new_size);
   assign best_idx_wide = 32'(best_idx_ff);

   assign wr_en   = (cmd.load && load_in_range) || (cmd.finish && best_found_ff);
   assign wr_addr = cmd.load ? IDX_BITS'(req_index) : best_idx_ff;
   assign wr_data = cmd.load ? amount_sized : new_size;

   bfa_ram #(
      .WIDTH (SIZE_BITS),
      .DEPTH (NUM_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (cnt_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_granted_ff <= best_found_ff;
         rsp_block_ff   <= best_found_ff ? best_idx_wide[3:0] : '0;
         rsp_left_ff    <= best_found_ff ? new_size_wide[15:0] : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_granted_ff;
   assign rsp_tdata  = {4'b0, rsp_left_ff, rsp_block_ff};

   assign status.is_alloc   = (req_tuser == bfa_pkg::REQ_ALLOC);
   assign status.limit_zero = (limit == '0);
   assign status.scan_last  = (CNT_BITS'(cnt_ff) + CNT_BITS'(1)) == limit;
   assign status.rsp_free   = !rsp_valid_ff || rsp_tready;

   a_finish_room: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten while a beat still waits");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> (CNT_BITS'(cnt_ff) < limit))
      else $error("scan read beyond the blocks in use");

   a_refusal_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_granted_ff) |-> (rsp_block_ff == '0 && rsp_left_ff == '0))
      else $error("refused result carries nonzero fields");

   a_grant_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && best_found_ff) |-> (CNT_BITS'(best_idx_ff) < limit))
      else $error("granted block lies outside the searched range");

endmodule

@@ rtl/best_fit_block_allocator.sv @@
// Top level of the best-fit block allocator: controller plus datapath.
// A load beat is accepted back to back.
// An allocation beat scans N = min(blocks_in_use, NUM_BLOCKS) entries, one per cycle; its
// result is registered when the controller leaves FINISH, and the next beat is accepted
// once it is back in IDLE. A result held back by rsp_tready stalls the input.
// Synchronous reset clears control state and blocks_in_use; the table is undefined until loaded.
module best_fit_block_allocator #(
   parameter int NUM_BLOCKS = bfa_pkg::NUM_BLOCKS_DEFAULT,
   parameter int SIZE_BITS  = bfa_pkg::SIZE_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // req_tdata: entry_index [3:0], amount [19:4], zero [23:20]
   input  logic [bfa_pkg::TDATA_BITS-1:0] req_tdata,
   // req_tuser: req_type [0]
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // rsp_tdata: chosen_block [3:0], size_left [19:4], zero [23:20]
   output logic [bfa_pkg::TDATA_BITS-1:0] rsp_tdata,
   // rsp_tuser: granted [0]
   output logic                           rsp_tuser,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bfa_pkg::CSR_BITS-1:0]   csr_data
);

   bfa_pkg::cmd_type    cmd;
   bfa_pkg::status_type status;

   assign csr_ready = 1'b1;

   bfa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bfa_datapath #(
      .NUM_BLOCKS (NUM_BLOCKS),
      .SIZE_BITS  (SIZE_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the best-fit block allocator with its own predictor.
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NBLK        = 16;
   localparam int SETTLE_CYC  = 24;   // longer than one full scan of all 16 entries

   typedef struct packed {
      logic        granted;
      logic [3:0]  blk;
      logic [15:0] left;
   } grant_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [bfa_pkg::TDATA_BITS-1:0]   req_tdata = '0;
   logic                             req_tuser = bfa_pkg::REQ_LOAD;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [bfa_pkg::TDATA_BITS-1:0]   rsp_tdata;
   logic                             rsp_tuser;
   logic                             csr_valid = 1'b0;
   logic                             csr_ready;
   logic [bfa_pkg::CSR_BITS-1:0]     csr_data = '0;

   // Predictor state: the free-size table and the number of blocks searched.
   logic [15:0]             free_tbl [NBLK];
   logic [4:0]              blocks_cfg;
   grant_type               pending_grants [$];
   int unsigned             error_count = 0;
   bit                      idle_on = 1'b1;
   int unsigned             stall_left = 0;

   best_fit_block_allocator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   initial begin
      #1_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Applies one accepted beat to the table and queues the grant it causes.
   task automatic apply_beat(input logic kind, input logic [3:0] idx,
                             input logic [15:0] amt);
      int        limit;
      int        best;
      bit        found;
      grant_type g;
      found = 1'b0;
      best  = 0;
      if (kind == bfa_pkg::REQ_LOAD) begin
         free_tbl[idx] = amt;
      end else begin
         limit = (blocks_cfg > NBLK) ? NBLK : blocks_cfg;
         for (int j = 0; j < limit; j++) begin
            if (free_tbl[j] >= amt && (!found || free_tbl[j] < free_tbl[best])) begin
               best  = j;
               found = 1'b1;
            end
         end
         if (found) begin
            free_tbl[best] = free_tbl[best] - amt;
            g = '{granted: 1'b1, blk: best[3:0], left: free_tbl[best]};
         end else begin
            g = '{granted: 1'b0, blk: 4'd0, left: 16'd0};
         end
         pending_grants.push_back(g);
      end
   endtask

   task automatic send_item(input logic kind, input logic [3:0] idx,
                            input logic [15:0] amt);
      @(negedge clock);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = kind;
      req_tdata  = {4'b0000, amt, idx};
      do @(posedge clock); while (!req_tready);
      apply_beat(kind, idx, amt);
   endtask

   // Drops valid and waits until every grant is back and the scan has settled.
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_grants.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_blocks_in_use(input logic [4:0] value);
      wait_drained();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      blocks_cfg = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Receiver: ready drops in random bursts while idling is enabled.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready = 1'b0;
         stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_tready = 1'b0;
         stall_left = $urandom_range(1, 11) - 1;
      end else begin
         rsp_tready = 1'b1;
      end
   end

   always @(posedge clock) begin
      grant_type exp_g;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_grants.size() == 0) begin
            $display("%0t: unexpected result beat granted=%0b block=%0d left=%0d",
                     $time, rsp_tuser, rsp_tdata[3:0], rsp_tdata[19:4]);
            error_count++;
         end else begin
            exp_g = pending_grants.pop_front();
            if (rsp_tuser !== exp_g.granted) begin
               $display("%0t: granted expected %0b actual %0b",
                        $time, exp_g.granted, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[3:0] !== exp_g.blk) begin
               $display("%0t: chosen_block expected %0d actual %0d",
                        $time, exp_g.blk, rsp_tdata[3:0]);
               error_count++;
            end
            if (rsp_tdata[19:4] !== exp_g.left) begin
               $display("%0t: size_left expected %0d actual %0d",
                        $time, exp_g.left, rsp_tdata[19:4]);
               error_count++;
            end
            if (rsp_tdata[23:20] !== 4'b0000) begin
               $display("%0t: tdata padding expected 0 actual %h",
                        $time, rsp_tdata[23:20]);
               error_count++;
            end
         end
      end
   end

   // With no blocks in use every request is refused; then the whole table is loaded
   // so that no later search can touch an entry that was never written.
   task automatic test_refusal_and_load();
      logic [15:0] init_val;
      send_item(bfa_pkg::REQ_ALLOC, 4'd0, 16'h0000);
      send_item(bfa_pkg::REQ_ALLOC, 4'hF, 16'hFFFF);
      for (int i = 0; i < NBLK; i++) begin
         case (i)
            0:       init_val = 16'hFFFF;
            1:       init_val = 16'h0000;
            3, 7:    init_val = 16'd100;
            5:       init_val = 16'h5555;
            9:       init_val = 16'hAAAA;
            default: init_val = 16'd1000 + 16'(i * 16);
         endcase
         send_item(bfa_pkg::REQ_LOAD, i[3:0], init_val);
      end
   endtask

   task automatic test_directed_fits();
      write_blocks_in_use(5'd16);
      send_item(bfa_pkg::REQ_ALLOC, 4'd0, 16'd60);      // tie between two equal entries
      send_item(bfa_pkg::REQ_ALLOC, 4'd0, 16'd100);     // exact fit leaves zero
      send_item(bfa_pkg::REQ_ALLOC, 4'd0, 16'd0);       // zero request takes the smallest entry
      send_item(bfa_pkg::REQ_ALLOC, 4'd0, 16'hFFFF);    // largest request fits the largest entry
      send_item(bfa_pkg::REQ_ALLOC, 4'd0, 16'hFFFF);    // nothing large enough is left
      write_blocks_in_use(5'd31);                       // above the table size, clamps to all
      send_item(bfa_pkg::REQ_ALLOC, 4'd0, 16'd1);
      write_blocks_in_use(5'd1);
      send_item(bfa_pkg::REQ_ALLOC, 4'd0, 16'd1);
   endtask

   task automatic random_phase(input int unsigned n_items);
      int          limit;
      int          pick;
      logic [15:0] amt;
      for (int unsigned k = 0; k < n_items; k++) begin
         if ($urandom_range(0, 9) < 4) begin
            amt = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 2000))
                                             : 16'($urandom);
            send_item(bfa_pkg::REQ_LOAD, 4'($urandom_range(0, NBLK - 1)), amt);
         end else begin
            limit = (blocks_cfg > NBLK) ? NBLK : blocks_cfg;
            case ($urandom_range(0, 9))
               0:       amt = 16'h0000;
               1:       amt = 16'hFFFF;
               2:       amt = 16'($urandom);
               default: begin
                  // Most requests are sized from a live entry so that grants are common.
                  pick = (limit == 0) ? 0 : $urandom_range(0, limit - 1);
                  amt  = 16'($urandom_range(0, free_tbl[pick]));
               end
            endcase
            send_item(bfa_pkg::REQ_ALLOC, 4'($urandom), amt);
         end
         if (k == n_items / 2 && $urandom_range(0, 1) == 0) begin
            wait_drained();
         end
      end
   endtask

   task automatic test_random_settings();
      write_blocks_in_use(5'd16);
      random_phase(200);
      write_blocks_in_use(5'd0);
      random_phase(40);
      write_blocks_in_use(5'd2);
      random_phase(120);
      write_blocks_in_use(5'd31);
      random_phase(150);
      for (int p = 0; p < 3; p++) begin
         write_blocks_in_use(5'($urandom_range(1, 31)));
         random_phase(100);
      end
   endtask

   task automatic test_back_to_back();
      wait_drained();
      idle_on = 1'b0;
      write_blocks_in_use(5'd16);
      random_phase(200);
   endtask

   initial begin
      blocks_cfg = 5'd0;
      for (int i = 0; i < NBLK; i++) free_tbl[i] = 16'd0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_refusal_and_load();
      test_directed_fits();
      test_random_settings();
      test_back_to_back();

      wait_drained();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
